[design/tefr_pkg.sv]
// Package for the triggered event ring forwarder.
// Holds the request, result, queue and CSR types, the mode codes and the state enum.
// No dependencies.
package tefr_pkg;

   localparam int unsigned ACT_BITS       = 32;
   localparam int unsigned PEND_BITS      = 14;
   localparam int unsigned CNT_BITS       = 32;
   localparam int unsigned MODE_BITS      = 3;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [PEND_BITS-1:0] MAX_PENDING_RESET = 14'd10000;

   localparam logic [MODE_BITS-1:0] MODE_ACTIVITY = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_TRIGGER  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_CLEAR    = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_CONFIRM  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_ERROR    = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_FORWARD_ALL = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_PENDING = 2'd1;

   typedef enum logic [2:0] {
      CMD_ACTIVITY,
      CMD_TRIGGER,
      CMD_CLEAR,
      CMD_CONFIRM,
      CMD_ERROR,
      CMD_NONE
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN_CHECK,
      ST_DRAIN_SEND,
      ST_CLOSE
   } back_state_type;

   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [ACT_BITS-1:0]  activity_word;
      logic                 still_ongoing;
   } req_type;

   typedef struct packed {
      logic                 send_valid;
      logic [ACT_BITS-1:0]  activity_out;
      logic                 last;
      logic [PEND_BITS-1:0] pending_count;
      logic [CNT_BITS-1:0]  dropped_count;
      logic [CNT_BITS-1:0]  dropped_in_anomaly;
      logic [CNT_BITS-1:0]  confirmed_count;
      logic [CNT_BITS-1:0]  error_count;
      logic                 anomaly_flag;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [ACT_BITS-1:0] word;
      logic                ongoing;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_head_type;

   typedef struct packed {
      logic                      valid;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  data;
   } csr_write_type;

endpackage

[design/tefr_front.sv]
// Front end of the forwarder: accepts requests, classifies the mode and queues commands.
// Depends on tefr_pkg.
module tefr_front #(
   parameter int unsigned WORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  tefr_pkg::req_type       req_data,
   output tefr_pkg::queue_head_type head,
   input  logic                    pop
);

   localparam logic [tefr_pkg::ACT_BITS-1:0] WORD_MASK = (WORD_BITS >= tefr_pkg::ACT_BITS) ?
      {tefr_pkg::ACT_BITS{1'b1}} :
      tefr_pkg::ACT_BITS'((64'd1 << WORD_BITS) - 64'd1);

   tefr_pkg::cmd_type entry_ff [2];
   tefr_pkg::cmd_type cmd_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic              wr_ptr_ff, wr_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              do_pop;

   always_comb begin
      cmd_in.word    = req_data.activity_word & WORD_MASK;
      cmd_in.ongoing = req_data.still_ongoing;
      unique case (req_data.mode)
         tefr_pkg::MODE_ACTIVITY: cmd_in.kind = tefr_pkg::CMD_ACTIVITY;
         tefr_pkg::MODE_TRIGGER:  cmd_in.kind = tefr_pkg::CMD_TRIGGER;
         tefr_pkg::MODE_CLEAR:    cmd_in.kind = tefr_pkg::CMD_CLEAR;
         tefr_pkg::MODE_CONFIRM:  cmd_in.kind = tefr_pkg::CMD_CONFIRM;
         tefr_pkg::MODE_ERROR:    cmd_in.kind = tefr_pkg::CMD_ERROR;
         default:                 cmd_in.kind = tefr_pkg::CMD_NONE;
      endcase
   end

   assign busy       = (count_ff == 2'd2);
   assign push       = start & ~busy;
   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_pop     = pop & head.valid;

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(do_pop);
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

[design/tefr_back.sv]
// Back end of the forwarder: credit accounting, counters, the flight recorder ring and drain.
// Depends on tefr_pkg; fed by tefr_front.
module tefr_back #(
   parameter int unsigned RING_DEPTH = 32,
   parameter int unsigned WORD_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tefr_pkg::queue_head_type head,
   output logic                     pop,
   input  tefr_pkg::csr_write_type  csr,
   output logic                     rsp_strobe,
   output tefr_pkg::rsp_type        rsp_data
);

   localparam int unsigned PTR_BITS   = $clog2(RING_DEPTH);
   localparam int unsigned STORE_BITS = (WORD_BITS < tefr_pkg::ACT_BITS) ?
                                        WORD_BITS : tefr_pkg::ACT_BITS;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(RING_DEPTH - 1);

   tefr_pkg::back_state_type state_ff, state_in;

   logic [STORE_BITS-1:0] ring_mem [RING_DEPTH];
   logic [STORE_BITS-1:0] rd_data_ff;
   logic [RING_DEPTH-1:0] slot_valid_ff, slot_valid_in;
   logic [PTR_BITS-1:0]   write_pos_ff, write_pos_in;
   logic [PTR_BITS-1:0]   drain_pos_ff, drain_pos_in;
   logic [PTR_BITS-1:0]   drain_cnt_ff, drain_cnt_in;
   logic                  anomaly_ff, anomaly_in;
   logic [tefr_pkg::PEND_BITS-1:0] pending_ff, pending_in;
   logic [tefr_pkg::CNT_BITS-1:0]  dropped_ff, dropped_in;
   logic [tefr_pkg::CNT_BITS-1:0]  dropped_anomaly_ff, dropped_anomaly_in;
   logic [tefr_pkg::CNT_BITS-1:0]  confirmed_ff, confirmed_in;
   logic [tefr_pkg::CNT_BITS-1:0]  errors_ff, errors_in;
   logic                           forward_all_ff;
   logic [tefr_pkg::PEND_BITS-1:0] max_pending_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   tefr_pkg::rsp_type              rsp_ff, rsp_in;

   logic                          ring_we;
   logic                          credit_ok;
   logic                          last_slot;
   logic                          emit;
   logic                          emit_last;
   logic                          send;
   logic [tefr_pkg::ACT_BITS-1:0] send_word;
   logic [tefr_pkg::ACT_BITS-1:0] drain_word;
   logic [tefr_pkg::PEND_BITS-1:0] pending_dec;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   assign credit_ok   = (pending_ff < max_pending_ff);
   assign last_slot   = (drain_cnt_ff == LAST_PTR);
   assign pending_dec = (pending_ff != '0) ? pending_ff - 1'b1 : pending_ff;
   assign pop         = (state_ff == tefr_pkg::ST_IDLE) & head.valid;

   always_comb begin
      drain_word                 = '0;
      drain_word[STORE_BITS-1:0] = rd_data_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tefr_pkg::ST_IDLE: begin
            if (head.valid && head.cmd.kind == tefr_pkg::CMD_TRIGGER) begin
               state_in = tefr_pkg::ST_DRAIN_CHECK;
            end
         end
         tefr_pkg::ST_DRAIN_CHECK: begin
            state_in = slot_valid_ff[drain_pos_ff] ? tefr_pkg::ST_DRAIN_SEND :
                                                     tefr_pkg::ST_CLOSE;
         end
         tefr_pkg::ST_DRAIN_SEND: begin
            state_in = last_slot ? tefr_pkg::ST_CLOSE : tefr_pkg::ST_DRAIN_CHECK;
         end
         tefr_pkg::ST_CLOSE: begin
            state_in = tefr_pkg::ST_IDLE;
         end
         default: begin
            state_in = tefr_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      slot_valid_in      = slot_valid_ff;
      write_pos_in       = write_pos_ff;
      drain_pos_in       = drain_pos_ff;
      drain_cnt_in       = drain_cnt_ff;
      anomaly_in         = anomaly_ff;
      pending_in         = pending_ff;
      dropped_in         = dropped_ff;
      dropped_anomaly_in = dropped_anomaly_ff;
      confirmed_in       = confirmed_ff;
      errors_in          = errors_ff;
      ring_we            = 1'b0;
      emit               = 1'b0;
      emit_last          = 1'b0;
      send               = 1'b0;
      send_word          = '0;
      unique case (state_ff)
         tefr_pkg::ST_IDLE: begin
            if (head.valid) begin
               unique case (head.cmd.kind)
                  tefr_pkg::CMD_ACTIVITY: begin
                     emit      = 1'b1;
                     emit_last = 1'b1;
                     if (forward_all_ff || anomaly_ff) begin
                        if (credit_ok) begin
                           pending_in = pending_ff + 1'b1;
                           send       = 1'b1;
                           send_word  = head.cmd.word;
                        end else if (forward_all_ff) begin
                           dropped_in = dropped_ff + 1'b1;
                        end else begin
                           dropped_anomaly_in = dropped_anomaly_ff + 1'b1;
                        end
                     end else begin
                        ring_we = 1'b1;
                        if (write_pos_ff == drain_pos_ff && slot_valid_ff[write_pos_ff]) begin
                           drain_pos_in = next_ptr(drain_pos_ff);
                        end
                        slot_valid_in[write_pos_ff] = 1'b1;
                        write_pos_in                = next_ptr(write_pos_ff);
                     end
                  end
                  tefr_pkg::CMD_TRIGGER: begin
                     anomaly_in   = head.cmd.ongoing;
                     drain_cnt_in = '0;
                  end
                  tefr_pkg::CMD_CLEAR: begin
                     emit       = 1'b1;
                     emit_last  = 1'b1;
                     anomaly_in = 1'b0;
                  end
                  tefr_pkg::CMD_CONFIRM: begin
                     emit         = 1'b1;
                     emit_last    = 1'b1;
                     confirmed_in = confirmed_ff + 1'b1;
                     pending_in   = pending_dec;
                  end
                  tefr_pkg::CMD_ERROR: begin
                     emit       = 1'b1;
                     emit_last  = 1'b1;
                     errors_in  = errors_ff + 1'b1;
                     pending_in = pending_dec;
                  end
                  default: begin
                     emit      = 1'b1;
                     emit_last = 1'b1;
                  end
               endcase
            end
         end
         tefr_pkg::ST_DRAIN_CHECK: begin
            if (slot_valid_ff[drain_pos_ff]) begin
               slot_valid_in[drain_pos_ff] = 1'b0;
            end
         end
         tefr_pkg::ST_DRAIN_SEND: begin
            if (credit_ok) begin
               pending_in = pending_ff + 1'b1;
               emit       = 1'b1;
               send       = 1'b1;
               send_word  = drain_word;
            end
            if (last_slot) begin
               drain_pos_in = write_pos_ff;
            end else begin
               drain_pos_in = next_ptr(drain_pos_ff);
               drain_cnt_in = drain_cnt_ff + 1'b1;
            end
         end
         tefr_pkg::ST_CLOSE: begin
            emit      = 1'b1;
            emit_last = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in              = emit;
      rsp_in.send_valid         = send;
      rsp_in.activity_out       = send_word;
      rsp_in.last               = emit_last;
      rsp_in.pending_count      = pending_in;
      rsp_in.dropped_count      = dropped_in;
      rsp_in.dropped_in_anomaly = dropped_anomaly_in;
      rsp_in.confirmed_count    = confirmed_in;
      rsp_in.error_count        = errors_in;
      rsp_in.anomaly_flag       = anomaly_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= tefr_pkg::ST_IDLE;
         slot_valid_ff      <= '0;
         write_pos_ff       <= '0;
         drain_pos_ff       <= '0;
         drain_cnt_ff       <= '0;
         anomaly_ff         <= 1'b0;
         pending_ff         <= '0;
         dropped_ff         <= '0;
         dropped_anomaly_ff <= '0;
         confirmed_ff       <= '0;
         errors_ff          <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         slot_valid_ff      <= slot_valid_in;
         write_pos_ff       <= write_pos_in;
         drain_pos_ff       <= drain_pos_in;
         drain_cnt_ff       <= drain_cnt_in;
         anomaly_ff         <= anomaly_in;
         pending_ff         <= pending_in;
         dropped_ff         <= dropped_in;
         dropped_anomaly_ff <= dropped_anomaly_in;
         confirmed_ff       <= confirmed_in;
         errors_ff          <= errors_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forward_all_ff <= 1'b0;
         max_pending_ff <= tefr_pkg::MAX_PENDING_RESET;
      end else if (csr.valid) begin
         unique case (csr.index)
            tefr_pkg::CSR_FORWARD_ALL: forward_all_ff <= csr.data[0];
            tefr_pkg::CSR_MAX_PENDING: max_pending_ff <= csr.data[tefr_pkg::PEND_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[write_pos_ff] <= head.cmd.word[STORE_BITS-1:0];
      end
      rd_data_ff <= ring_mem[drain_pos_ff];
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

[design/triggered_event_ring_forwarder_unit.sv]
// Top level of the triggered event ring forwarder.
// Depends on tefr_pkg, tefr_front and tefr_back.
//
//   channel   ports                                    handshake
//   request   start, busy, req_data                    taken when start and not busy
//   result    rsp_strobe, rsp_data                     one cycle per result, no stall
//   csr       csr_valid, csr_ready, csr_index, csr_data written when valid and ready
//
// Activity, clear, confirm and error requests are handled one per cycle while no trigger drains;
// each is written into the command queue, and its result is registered before the strobe rises.
// A trigger passes through drain check and drain send for each ring entry drained, then close;
// the drain ends at an empty slot or after RING_DEPTH entries; each costs a check and a registered read.
// Reset clears all control state; there is no clearing pass.
// Busy rises when the two-entry command queue is full; it can fill while a trigger drains, as pops wait for idle.
module triggered_event_ring_forwarder_unit #(
   parameter int unsigned RING_DEPTH = 32,
   parameter int unsigned WORD_BITS  = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  tefr_pkg::req_type                      req_data,
   output logic                                   rsp_strobe,
   output tefr_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tefr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [tefr_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   tefr_pkg::queue_head_type head;
   tefr_pkg::csr_write_type  csr;
   logic                     pop;

   assign csr_ready = 1'b1;
   assign csr.valid = csr_valid & csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;

   tefr_front #(
      .WORD_BITS (WORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .head     (head),
      .pop      (pop)
   );

   tefr_back #(
      .RING_DEPTH (RING_DEPTH),
      .WORD_BITS  (WORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .csr        (csr),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[design/tefr_checker.sv]
// Port-level checker for the triggered event ring forwarder, with its bind.
// Depends on tefr_pkg and triggered_event_ring_forwarder_unit.
module tefr_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input tefr_pkg::rsp_type rsp_data
);

   a_no_result_after_reset: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !rsp_strobe)
      else $error("result strobe right after reset");

   a_idle_word_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.send_valid) |-> (rsp_data.activity_out == '0))
      else $error("activity word not zero on a result without a send");

   a_send_holds_credit: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.send_valid) |-> (rsp_data.pending_count != '0))
      else $error("send reported with no outstanding credit");

   a_inner_is_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.last) |-> rsp_data.send_valid)
      else $error("non-final result that carries no send");

   a_error_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(rsp_strobe) && !$past(reset)) |->
         ((rsp_data.error_count == $past(rsp_data.error_count)) ||
          (rsp_data.error_count == $past(rsp_data.error_count) + 32'd1)))
      else $error("error count moved by more than one between results");

endmodule

bind triggered_event_ring_forwarder_unit tefr_checker u_checker (.*);
